[sv/aes_pkg.sv]
// Package: AES-128 types, tables and round functions.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_UPPER = 1'b0,
    REG_KEY_LOWER = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_t;

  typedef struct packed {
    logic         vld;
    mode_t        mode;
    logic [127:0] st;
    logic [127:0] rk_enc;
    logic [127:0] rk_dec;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] t [16];
    t = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};
    return t[r];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [7:0] byt(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // forward key schedule step, round index r (0-based rcon)
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // inverse key schedule step: from round key r+1 back to round key r
  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w3 = k[31:0] ^ k[63:32]; w2 = k[63:32] ^ k[95:64]; w1 = k[95:64] ^ k[127:96];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = k[127:96] ^ t;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = sbox(byt(s, 4*((c+r)%4)+r));
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {xt(a0)^xt(a1)^a1^a2^a3, a0^xt(a1)^xt(a2)^a2^a3,
                             a0^a1^xt(a2)^xt(a3)^a3, xt(a0)^a0^a1^a2^xt(a3)};
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction
  function automatic logic [7:0] mulb(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction
  function automatic logic [7:0] muld(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction
  function automatic logic [7:0] mule(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  // inverse round: state already keyed; optional InvMixColumns then inverse shift/sub
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic first);
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] m, o;
    for (int c = 0; c < 4; c++) begin
      a0 = byt(s, 4*c); a1 = byt(s, 4*c+1); a2 = byt(s, 4*c+2); a3 = byt(s, 4*c+3);
      if (first) begin
        m[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        m[127-32*c -: 32] = {mule(a0)^mulb(a1)^muld(a2)^mul9(a3),
                             mul9(a0)^mule(a1)^mulb(a2)^muld(a3),
                             muld(a0)^mul9(a1)^mule(a2)^mulb(a3),
                             mulb(a0)^muld(a1)^mul9(a2)^mule(a3)};
      end
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127-8*(4*c+r) -: 8] = inv_sbox(byt(m, 4*((c-r+4)%4)+r));
    return o;
  endfunction

endpackage

[sv/aes128_block_cipher_core.sv]
// Top level: AES-128 encrypt/decrypt pipeline of ten round cells.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: in_tuser = req_type (0 encrypt, 1 decrypt),
//   in_tdata = {block_in_lower, block_in_upper} (upper in bits 63:0).
//   Output channel out_*: out_tdata = {block_out_lower, block_out_upper}.
//   Config channel cfg_*: index 0 writes key_upper, index 1 key_lower.
//   After reset or a key write, an internal walk of the key schedule runs
//   before the decrypt round keys are ready; in_tready is low during that
//   walk. Write keys only while no item is in flight.
// Pipeline: an accepted item passes through ten round cells, one register
//   each, the input feeding the first cell directly; out_* is driven by the
//   register of the last cell.
// Throughput: one block per cycle unless stalled or in a key walk; each cell holds one block in flight.
// Stall: when out_tready is low and a result waits, the whole cell chain
//   holds and in_tready drops; bubbles in the chain are not squeezed out.
// Reset: keys clear to zero, the pipeline empties, the key walk restarts.
module aes128_block_cipher_core
  import aes_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [127:0]       in_tdata,   // block_in_upper, block_in_lower
  input  logic               in_tuser,   // req_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [127:0]       out_tdata,  // block_out_upper, block_out_lower
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [127:0] key0, key10;
  logic key_busy;
  stage_t chain [NumRounds+1];
  stage_t load;
  logic en;

  aes_key_prep u_key (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .key0, .key10, .busy(key_busy)
  );

  assign cfg_ready = 1'b1;
  assign en = out_tready || !chain[NumRounds].vld;
  assign in_tready = en && !key_busy;

  always_comb begin
    load.vld = in_tvalid && in_tready;
    load.mode = mode_t'(in_tuser);
    load.rk_enc = key0;
    load.rk_dec = key10;
    load.st = {in_tdata[63:0], in_tdata[127:64]};
    if (load.mode == MODE_ENC) load.st = load.st ^ key0;
  end
  assign chain[0] = load;

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk, .rst_n, .en, .rnd(4'(g)), .prev(chain[g]), .cur(chain[g+1])
    );
  end

  assign out_tvalid = chain[NumRounds].vld;
  assign out_tdata = {chain[NumRounds].st[63:0], chain[NumRounds].st[127:64]};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !key_busy |-> in_tready)
    else $error("chain stalled with empty output");

endmodule

[sv/aes_round_cell.sv]
// One round cell: a round of the cipher or inverse cipher plus one key schedule step.
`timescale 1ns / 1ps
module aes_round_cell
  import aes_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [3:0]    rnd,
  input  stage_t        prev,
  output stage_t        cur
);

  stage_t cell_r, cell_nxt;
  logic [127:0] rk_enc_new, rk_dec_new, dec_in;
  logic last;

  // encrypt: round rnd+1; decrypt: round 10-rnd with key held in rk_dec
  always_comb begin
    last = (rnd == 4'(NumRounds - 1));
    rk_enc_new = key_fwd(prev.rk_enc, rnd);
    rk_dec_new = key_bwd(prev.rk_dec, 4'(NumRounds - 1) - rnd);
    dec_in = prev.st ^ prev.rk_dec;
    cell_nxt.vld = prev.vld;
    cell_nxt.mode = prev.mode;
    cell_nxt.rk_enc = rk_enc_new;
    cell_nxt.rk_dec = rk_dec_new;
    if (prev.mode == MODE_DEC) begin
      cell_nxt.st = dec_round(dec_in, rnd == 4'd0);
      if (last) cell_nxt.st = cell_nxt.st ^ rk_dec_new;
    end else begin
      cell_nxt.st = enc_round(prev.st, last) ^ rk_enc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (en) begin
      cell_r.mode <= cell_nxt.mode;
      cell_r.st <= cell_nxt.st;
      cell_r.rk_enc <= cell_nxt.rk_enc;
      cell_r.rk_dec <= cell_nxt.rk_dec;
    end
  end

  assign cur = cell_r;

endmodule

[sv/aes_key_prep.sv]
// Key registers and the last round key derived for the inverse cipher.
`timescale 1ns / 1ps
module aes_key_prep
  import aes_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output logic [127:0]       key0,
  output logic [127:0]       key10,
  output logic               busy
);

  logic [63:0] key_upper_r, key_lower_r;
  logic [127:0] key10_r, k_nxt;
  logic [3:0] step_r;
  logic busy_r;

  // schedule walk after each write; config must be written only while idle, not enforced by this block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      step_r <= '0;
      busy_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEY_UPPER: key_upper_r <= cfg_data;
          REG_KEY_LOWER: key_lower_r <= cfg_data;
          default: ;
        endcase
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'(NumRounds - 1)) busy_r <= 1'b0;
      end
    end
  end

  always_comb k_nxt = key_fwd((step_r == 4'd0) ? key0 : key10_r, step_r);

  always_ff @(posedge clk) begin
    if (busy_r && !cfg_valid) key10_r <= k_nxt;
  end

  assign key0 = {key_upper_r, key_lower_r};
  assign key10 = key10_r;
  assign busy = busy_r;

endmodule
